>>> sv/ipa_pkg.sv
// ipa_pkg: types, codes and helpers shared by the index pool allocator
// holds the request and result structs and the controller/datapath command types
// no dependencies
`timescale 1ns / 1ps

package ipa_pkg;

    // pool geometry
    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

    // request function codes
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_IDLE    = 2'd1;
    localparam logic [1:0] ST_BUSY_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOT_BUSY   = 2'd3;

    // link write steps issued by the controller
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_SELF   = 2'd1;
    localparam logic [1:0] WR_UNLINK = 2'd2;
    localparam logic [1:0] WR_LINK   = 2'd3;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_index;
        logic [CNT_W-1:0] idle_total;
        logic [CNT_W-1:0] busy_total;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       rd;
        logic [1:0] wr_step;
        logic       commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_err;
    } t_dp_stat;

    // successor index in reset order, wrapping at the pool size
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(NUM_ENTRIES - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // predecessor index in reset order, wrapping at the pool size
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(NUM_ENTRIES - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

>>> sv/index_pool_allocator.sv
// index_pool_allocator: top level of the index pool allocator
// joins the sequencer ipa_ctrl and the datapath ipa_datapath
// depends on ipa_pkg, ipa_ctrl, ipa_datapath
`timescale 1ns / 1ps

// Hands out and takes back indices of a 16-entry pool kept on an idle and a busy
// circular doubly linked list. A request is taken when start is high and busy is
// low. A request that fails its check (no idle entry, busy list empty, index not
// in use) answers in the next cycle and leaves busy low, so another request may
// follow at once. A successful allocate or release keeps busy high while the link
// memories are read and the up to six changed links written in the self, unlink
// and link steps, since each link memory has one write port; the result is shown
// in the cycle after the link step, the first cycle a new request can be taken.
// Each result is on o_result for exactly one cycle with o_result_valid
// high and cannot be held off, so the receiver must take it in that cycle.

module index_pool_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  ipa_pkg::t_req    i_req,
    output logic             busy,
    output logic             o_result_valid,
    output ipa_pkg::t_result o_result
);
    import ipa_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    ipa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // lists, links and result
    ipa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // every entry is on exactly one list
    a_count_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            (CNT_W + 1)'(o_result.idle_total) + (CNT_W + 1)'(o_result.busy_total)
                == (CNT_W + 1)'(NUM_ENTRIES))
        else $error("idle and busy totals do not cover the pool");

    // a commit always produces a result transfer
    a_commit_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_result_valid)
        else $error("commit without result strobe");

    // no result transfer in the first cycle of a list update
    a_no_early_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_result_valid)
        else $error("result strobe at start of an update");

    // busy list empty report carries an empty busy count
    a_busy_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == ST_BUSY_EMPTY)) |->
            (o_result.busy_total == '0))
        else $error("busy list empty reported with nonzero busy count");

endmodule

>>> sv/ipa_ctrl.sv
// ipa_ctrl: sequencer for one allocate or release request
// steps the datapath through read, three link write steps and commit
// depends on ipa_pkg
`timescale 1ns / 1ps

module ipa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ipa_pkg::t_dp_stat i_stat,
    output logic            o_busy,
    output ipa_pkg::t_dp_cmd  o_cmd
);
    import ipa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SELF   = 3'd2;
    localparam logic [2:0] S_UNLINK = 3'd3;
    localparam logic [2:0] S_LINK   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.wr_step = WR_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (!i_stat.req_err) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SELF;
            end
            S_SELF: begin
                o_cmd.wr_step = WR_SELF;
                n_state       = S_UNLINK;
            end
            S_UNLINK: begin
                o_cmd.wr_step = WR_UNLINK;
                n_state       = S_LINK;
            end
            S_LINK: begin
                o_cmd.wr_step = WR_LINK;
                o_cmd.commit  = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> sv/ipa_datapath.sv
// ipa_datapath: link memories, list heads, counts and the result register
// executes read, link write and commit commands from the controller
// depends on ipa_pkg
`timescale 1ns / 1ps

module ipa_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipa_pkg::t_req     i_req,
    input  ipa_pkg::t_dp_cmd  i_cmd,
    output ipa_pkg::t_dp_stat o_stat,
    output ipa_pkg::t_result  o_result,
    output logic              o_result_valid
);
    import ipa_pkg::*;

    // link memories, entries without a valid bit read as their reset link
    logic [IDX_W-1:0]       r_next_mem [NUM_ENTRIES];
    logic [IDX_W-1:0]       r_prev_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_next_vld;
    logic [NUM_ENTRIES-1:0] r_prev_vld;
    logic [NUM_ENTRIES-1:0] r_in_use;

    // list heads and counts
    logic [IDX_W-1:0] r_idle_head;
    logic [IDX_W-1:0] r_busy_head;
    logic [CNT_W-1:0] r_idle_cnt;
    logic [CNT_W-1:0] r_busy_cnt;
    logic [CNT_W-1:0] n_idle_cnt;
    logic [CNT_W-1:0] n_busy_cnt;

    // operation context captured at accept
    logic             r_func;
    logic [IDX_W-1:0] r_e;
    logic [IDX_W-1:0] r_f;
    logic             r_unlink_en;
    logic             r_link_empty;

    // registered link reads: next[e], prev[e], prev[f]
    logic [IDX_W-1:0] r_ne_data;
    logic             r_ne_vld;
    logic [IDX_W-1:0] r_pe_data;
    logic             r_pe_vld;
    logic [IDX_W-1:0] r_pf_data;
    logic             r_pf_vld;

    logic [IDX_W-1:0] n_val;
    logic [IDX_W-1:0] p_val;
    logic [IDX_W-1:0] p2_val;

    // link write ports
    logic             next_we;
    logic [IDX_W-1:0] next_wa;
    logic [IDX_W-1:0] next_wd;
    logic             prev_we;
    logic [IDX_W-1:0] prev_wa;
    logic [IDX_W-1:0] prev_wd;

    logic [1:0]       req_status;
    logic [IDX_W-1:0] req_granted;

    t_result r_result;
    logic    r_result_valid;

    // request check against the current lists
    always_comb begin
        req_status  = ST_OK;
        req_granted = i_req.entry_index;
        if (i_req.func == FUNC_ALLOC) begin
            req_granted = '0;
            if (r_idle_cnt == '0) begin
                req_status = ST_NO_IDLE;
            end
        end else if (r_busy_cnt == '0) begin
            req_status = ST_BUSY_EMPTY;
        end else if (!r_in_use[i_req.entry_index]) begin
            req_status = ST_NOT_BUSY;
        end
    end

    assign o_stat.req_err = (req_status != ST_OK);

    // neighbor links, falling back to the reset ring where never written
    assign n_val  = r_ne_vld ? r_ne_data : idx_inc(r_e);
    assign p_val  = r_pe_vld ? r_pe_data : idx_dec(r_e);
    assign p2_val = r_pf_vld ? r_pf_data : idx_dec(r_f);

    // link write selection per step
    always_comb begin
        next_we = 1'b0;
        next_wa = r_e;
        next_wd = r_e;
        prev_we = 1'b0;
        prev_wa = r_e;
        prev_wd = r_e;
        case (i_cmd.wr_step)
            WR_SELF: begin
                next_we = 1'b1;
                next_wa = r_e;
                next_wd = r_link_empty ? r_e : r_f;
                prev_we = 1'b1;
                prev_wa = r_e;
                prev_wd = r_link_empty ? r_e : p2_val;
            end
            WR_UNLINK: begin
                next_we = r_unlink_en;
                next_wa = p_val;
                next_wd = n_val;
                prev_we = r_unlink_en;
                prev_wa = n_val;
                prev_wd = p_val;
            end
            WR_LINK: begin
                next_we = !r_link_empty;
                next_wa = p2_val;
                next_wd = r_e;
                prev_we = !r_link_empty;
                prev_wa = r_f;
                prev_wd = r_e;
            end
            default: begin
                next_we = 1'b0;
                prev_we = 1'b0;
            end
        endcase
    end

    // link memories with registered reads
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (i_cmd.rd) begin
            r_ne_data <= r_next_mem[r_e];
            r_ne_vld  <= r_next_vld[r_e];
            r_pe_data <= r_prev_mem[r_e];
            r_pe_vld  <= r_prev_vld[r_e];
            r_pf_data <= r_prev_mem[r_f];
            r_pf_vld  <= r_prev_vld[r_f];
        end
    end

    // valid bits for written link entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
            r_prev_vld <= '0;
        end else begin
            if (next_we) begin
                r_next_vld[next_wa] <= 1'b1;
            end
            if (prev_we) begin
                r_prev_vld[prev_wa] <= 1'b1;
            end
        end
    end

    // operation context
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_req.func;
            if (i_req.func == FUNC_ALLOC) begin
                r_e          <= r_idle_head;
                r_f          <= r_busy_head;
                r_unlink_en  <= (r_idle_cnt > CNT_W'(1));
                r_link_empty <= (r_busy_cnt == '0);
            end else begin
                r_e          <= i_req.entry_index;
                r_f          <= r_idle_head;
                r_unlink_en  <= (r_busy_cnt > CNT_W'(1));
                r_link_empty <= (r_idle_cnt == '0);
            end
        end
    end

    // counts after this operation
    always_comb begin
        if (r_func == FUNC_ALLOC) begin
            n_idle_cnt = r_idle_cnt - CNT_W'(1);
            n_busy_cnt = r_busy_cnt + CNT_W'(1);
        end else begin
            n_idle_cnt = r_idle_cnt + CNT_W'(1);
            n_busy_cnt = r_busy_cnt - CNT_W'(1);
        end
    end

    // heads, counts and in-use marks at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_head <= '0;
            r_busy_head <= '0;
            r_idle_cnt  <= CNT_W'(NUM_ENTRIES);
            r_busy_cnt  <= '0;
            r_in_use    <= '0;
        end else if (i_cmd.commit) begin
            r_idle_cnt <= n_idle_cnt;
            r_busy_cnt <= n_busy_cnt;
            if (r_func == FUNC_ALLOC) begin
                r_busy_head   <= r_e;
                r_in_use[r_e] <= 1'b1;
                if (r_unlink_en) begin
                    r_idle_head <= n_val;
                end
            end else begin
                r_idle_head   <= r_e;
                r_in_use[r_e] <= 1'b0;
                if (r_unlink_en) begin
                    r_busy_head <= n_val;
                end
            end
        end
    end

    // result register, errors answer at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result.status        <= ST_OK;
            r_result.granted_index <= r_e;
            r_result.idle_total    <= n_idle_cnt;
            r_result.busy_total    <= n_busy_cnt;
        end else if (i_cmd.accept && o_stat.req_err) begin
            r_result.status        <= req_status;
            r_result.granted_index <= req_granted;
            r_result.idle_total    <= r_idle_cnt;
            r_result.busy_total    <= r_busy_cnt;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.commit || (i_cmd.accept && o_stat.req_err);
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

endmodule
